/* hdl/particle_contact_resolve_top_defines.svh */
// Assertion macros shared by the contact resolver modules.
// Included by the files that carry concurrent checks; needs nothing else.
`ifndef PARTICLE_CONTACT_RESOLVE_TOP_DEFINES_SVH
`define PARTICLE_CONTACT_RESOLVE_TOP_DEFINES_SVH

// Same-cycle implication, switched off during reset.
`define PRC_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off during reset.
`define PRC_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/prc_pkg.sv */
// Shared types and fixed constants of the particle contact resolver.
// No dependencies; imported by prc_front, prc_back and the top level.
package prc_pkg;

  localparam int VEC_W     = 48;
  localparam int MASS_W    = 16;
  localparam int PEN_W     = 16;
  localparam int REST_W    = 9;
  localparam int STEP_W    = 16;
  localparam int REST_FRAC = 8;
  localparam int STEP_FRAC = 16;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd1092;

  typedef struct packed {
    logic [VEC_W-1:0]        vel_first;
    logic [VEC_W-1:0]        vel_second;
    logic [VEC_W-1:0]        acc_first;
    logic [VEC_W-1:0]        acc_second;
    logic [VEC_W-1:0]        pos_first;
    logic [VEC_W-1:0]        pos_second;
    logic [VEC_W-1:0]        contact_normal;
    logic [MASS_W-1:0]       inv_mass_first;
    logic [MASS_W-1:0]       inv_mass_second;
    logic signed [PEN_W-1:0] penetration;
    logic [REST_W-1:0]       restitution;
    logic                    has_second;
  } contact_t;

  typedef struct packed {
    logic [VEC_W-1:0] new_vel_first;
    logic [VEC_W-1:0] new_vel_second;
    logic [VEC_W-1:0] new_pos_first;
    logic [VEC_W-1:0] new_pos_second;
    logic             impulse_applied;
  } result_t;

endpackage

/* hdl/prc_queue.sv */
// Small register queue used between the front and back parts and at the output.
// Depends on the assertion macros header; DEPTH must be a power of two.
`include "particle_contact_resolve_top_defines.svh"

module prc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             pop,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic             full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  `PRC_ASSERT_IMP(a_no_overflow, clk, rst, push, !full, "queue written while full")
  `PRC_ASSERT_IMP(a_no_underflow, clk, rst, pop, !empty, "queue read while empty")

endmodule

/* hdl/prc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, for the back part.
// Stands alone; every stage register advances only while en is high.
module prc_div #(
  parameter int NUM_W = 37,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot
);

  logic [DEN_W-1:0] rem_s [NUM_W];
  logic [NUM_W-1:0] nq_s  [NUM_W+1];
  logic [DEN_W-1:0] den_s [NUM_W+1];
  logic [DEN_W:0]   trial [NUM_W];
  logic [DEN_W:0]   diff  [NUM_W];
  logic             ge    [NUM_W];

  // The numerator shifts out at the top while quotient bits enter at the bottom.
  always_comb begin
    for (int k = 0; k < NUM_W; k++) begin
      trial[k] = {rem_s[k], nq_s[k][NUM_W-1]};
      ge[k]    = (trial[k] >= {1'b0, den_s[k]});
      diff[k]  = trial[k] - {1'b0, den_s[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= '0;
      nq_s[0]  <= num;
      den_s[0] <= den;
      for (int k = 0; k < NUM_W; k++) begin
        if (k < NUM_W - 1) begin
          rem_s[k+1] <= ge[k] ? diff[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
        end
        nq_s[k+1]  <= {nq_s[k][NUM_W-2:0], ge[k]};
        den_s[k+1] <= den_s[k];
      end
    end
  end

  assign quot = nq_s[NUM_W];

endmodule

/* hdl/prc_front.sv */
// Front part: accepts contacts, forms the dot products and the division numerators.
// Uses prc_pkg and the assertion macros; feeds the queue ahead of the back part.
`include "particle_contact_resolve_top_defines.svh"

module prc_front import prc_pkg::*; #(
  parameter int W     = 16,
  parameter int F     = 8,
  parameter int DEPTH = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  contact_t               contact,
  input  logic [STEP_W-1:0]      time_step,
  input  logic                   mid_pop,
  output logic                   out_valid,
  output contact_t               out_item,
  output logic [2*W+4:0]         out_num,
  output logic [2*W+4:0]         out_pnum,
  output logic [W:0]             out_total,
  output logic                   out_apply,
  output logic                   out_pos
);

  localparam int VW = 3 * W;
  localparam int PW = 2 * W + 1;
  localparam int SW = 2 * W + 3;
  localparam int EW = SW + REST_W + 1;
  localparam int A  = 2 * W + 5;
  localparam int OW = $clog2(DEPTH + 1);

  logic          accept;
  logic [OW-1:0] occ;

  logic [VW-1:0]       vf, vs, af, as2, nn;
  logic signed [W:0]   dv [3];
  logic signed [W:0]   da [3];
  logic signed [PW-1:0] pv_c [3];
  logic signed [PW-1:0] pa_c [3];

  logic                 vld1, vld2, vld3, vld4, vld5;
  contact_t             it1, it2, it3, it4, it5;
  logic signed [PW-1:0] pv1 [3];
  logic signed [PW-1:0] pa1 [3];
  logic signed [SW-1:0] sep2, acc2;
  logic [W:0]           tot2, tot3, tot4, tot5;
  logic signed [SW+STEP_W:0] accprod;
  logic signed [SW-1:0] nsep_c;
  logic signed [SW-1:0] acs3, nsep3, nsep4;
  logic signed [EW-1:0] nse3, nse4, acce_c, acce4;
  logic                 apply3, apply4, apply5, pos3, pos4, pos5;
  logic signed [W-1:0]  pw2, pw4;
  logic signed [EW:0]   ns_c;
  logic [EW:0]          nsc;
  logic [A-1:0]         num5, pnum5;

  assign accept = push && !full;
  assign full   = (occ == OW'(DEPTH));

  // Occupancy counts contacts accepted but not yet taken from the queue, so the
  // pipeline never needs to stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= '0;
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      vld5 <= 1'b0;
    end else begin
      occ  <= occ + OW'(accept) - OW'(mid_pop);
      vld1 <= accept;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
      vld5 <= vld4;
    end
  end

  assign vf  = VW'(contact.vel_first);
  assign vs  = VW'(contact.vel_second);
  assign af  = VW'(contact.acc_first);
  assign as2 = VW'(contact.acc_second);
  assign nn  = VW'(contact.contact_normal);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv[i] = (W+1)'($signed(vf[i*W +: W]));
      da[i] = (W+1)'($signed(af[i*W +: W]));
      if (contact.has_second) begin
        dv[i] = dv[i] - (W+1)'($signed(vs[i*W +: W]));
        da[i] = da[i] - (W+1)'($signed(as2[i*W +: W]));
      end
      pv_c[i] = dv[i] * $signed(nn[i*W +: W]);
      pa_c[i] = da[i] * $signed(nn[i*W +: W]);
    end
  end

  assign pw2     = $signed(W'($unsigned(it2.penetration)));
  assign accprod = acc2 * $signed({1'b0, time_step});
  assign nsep_c  = -sep2;
  assign acce_c  = acs3 * $signed({1'b0, it3.restitution});
  assign ns_c    = (EW+1)'(nse4) + (EW+1)'(acce4);
  assign nsc     = (ns_c < 0) ? '0 : $unsigned(ns_c);

  always_ff @(posedge clk) begin
    it1 <= contact;
    for (int i = 0; i < 3; i++) begin
      pv1[i] <= pv_c[i];
      pa1[i] <= pa_c[i];
    end

    it2  <= it1;
    sep2 <= SW'(pv1[0]) + SW'(pv1[1]) + SW'(pv1[2]);
    acc2 <= SW'(pa1[0]) + SW'(pa1[1]) + SW'(pa1[2]);
    tot2 <= {1'b0, W'(it1.inv_mass_first)}
          + (it1.has_second ? {1'b0, W'(it1.inv_mass_second)} : '0);

    // Acceleration term rounds toward minus infinity through the arithmetic slice.
    it3    <= it2;
    tot3   <= tot2;
    acs3   <= accprod[SW+STEP_FRAC-1:STEP_FRAC];
    nsep3  <= nsep_c;
    nse3   <= nsep_c * $signed({1'b0, it2.restitution});
    apply3 <= (sep2 <= 0) && (tot2 != '0);
    pos3   <= (pw2 > 0) && (tot2 != '0);

    it4    <= it3;
    tot4   <= tot3;
    nsep4  <= nsep3;
    nse4   <= nse3;
    apply4 <= apply3;
    pos4   <= pos3;
    pw4    <= $signed(W'($unsigned(it3.penetration)));
    if (acs3 < 0) begin
      acce4 <= acce_c;
    end else begin
      acce4 <= '0;
    end

    it5    <= it4;
    tot5   <= tot4;
    apply5 <= apply4;
    pos5   <= pos4;
    num5   <= apply4 ? (A'(nsc[EW:REST_FRAC]) + A'(nsep4)) : '0;
    pnum5  <= pos4 ? (A'($unsigned(pw4)) << F) : '0;
  end

  assign out_valid = vld5;
  assign out_item  = it5;
  assign out_num   = num5;
  assign out_pnum  = pnum5;
  assign out_total = tot5;
  assign out_apply = apply5;
  assign out_pos   = pos5;

  `PRC_ASSERT_NXT(a_occ_tracks_accept, clk, rst, accept, occ != '0,
                  "accepted contact not counted in occupancy")

endmodule

/* hdl/prc_back.sv */
// Back part: divides out the impulse and push amounts, scales them by inverse
// mass and normal, and saturates the new vectors. Uses prc_pkg and prc_div.
module prc_back import prc_pkg::*; #(
  parameter int W = 16,
  parameter int F = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           mid_empty,
  output logic           mid_pop,
  input  contact_t       item,
  input  logic [2*W+4:0] num,
  input  logic [2*W+4:0] pnum,
  input  logic [W:0]     total,
  input  logic           apply,
  input  logic           pos,
  input  logic           out_full,
  output logic           out_valid,
  output result_t        result
);

  localparam int VW  = 3 * W;
  localparam int A   = 2 * W + 5;
  localparam int LD  = A + 1;
  localparam int PCW = W + F + 2;
  localparam int DW  = 2 * W + 3;
  localparam int MW  = A + W;
  localparam logic [PCW-1:0] PC_MAX = PCW'(1) << (W + F + 1);
  localparam logic signed [DW:0] SAT_HI = (DW+1)'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [DW:0] SAT_LO = ~SAT_HI;

  logic         en;
  logic [A-1:0] q_imp, q_pos;

  contact_t sd_item  [LD];
  logic     sd_apply [LD];
  logic     sd_pos   [LD];
  logic     sd_vld   [LD];

  logic [A-1:0]   amt  [4];
  logic [W-1:0]   imw  [4];
  logic [MW-1:0]  prod [4];
  logic [MW-1:0]  psh  [4];
  logic [PCW-1:0] pc1  [4];
  contact_t       it1, it2;
  logic           ap1, ap2, vp1, vp2, vp3;
  logic [VW-1:0]  nv1;
  logic signed [PCW+W:0] dprod [4][3];
  logic signed [DW-1:0]  dd2   [4][3];
  logic [VW-1:0]  vv1, vv2, pp1, pp2;
  logic [VW-1:0]  rv1, rv2, rp1, rp2;
  result_t        res3;

  function automatic logic [W-1:0] sat(input logic signed [DW:0] x);
    if (x > SAT_HI) begin
      return SAT_HI[W-1:0];
    end else if (x < SAT_LO) begin
      return SAT_LO[W-1:0];
    end
    return x[W-1:0];
  endfunction

  // The whole back pipeline holds while a finished result cannot enter the output queue.
  assign en      = !(vp3 && out_full);
  assign mid_pop = en && !mid_empty;

  prc_div #(.NUM_W(A), .DEN_W(W + 1)) u_div_imp (
    .clk  (clk),
    .en   (en),
    .num  (num),
    .den  (total),
    .quot (q_imp)
  );

  prc_div #(.NUM_W(A), .DEN_W(W + 1)) u_div_pos (
    .clk  (clk),
    .en   (en),
    .num  (pnum),
    .den  (total),
    .quot (q_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LD; k++) begin
        sd_vld[k] <= 1'b0;
      end
      vp1 <= 1'b0;
      vp2 <= 1'b0;
      vp3 <= 1'b0;
    end else if (en) begin
      sd_vld[0] <= mid_pop;
      for (int k = 1; k < LD; k++) begin
        sd_vld[k] <= sd_vld[k-1];
      end
      vp1 <= sd_vld[LD-1];
      vp2 <= vp1;
      vp3 <= vp2;
    end
  end

  always_comb begin
    amt[0] = sd_apply[LD-1] ? q_imp : '0;
    amt[1] = amt[0];
    amt[2] = sd_pos[LD-1] ? q_pos : '0;
    amt[3] = amt[2];
    imw[0] = W'(sd_item[LD-1].inv_mass_first);
    imw[1] = sd_item[LD-1].has_second ? W'(sd_item[LD-1].inv_mass_second) : '0;
    imw[2] = imw[0];
    imw[3] = imw[1];
    for (int j = 0; j < 4; j++) begin
      prod[j] = MW'(amt[j]) * MW'(imw[j]);
      psh[j]  = prod[j] >> F;
    end
  end

  assign nv1 = VW'(it1.contact_normal);

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 3; i++) begin
        dprod[j][i] = $signed({1'b0, pc1[j]}) * $signed(nv1[i*W +: W]);
      end
    end
  end

  assign vv1 = VW'(it2.vel_first);
  assign vv2 = VW'(it2.vel_second);
  assign pp1 = VW'(it2.pos_first);
  assign pp2 = VW'(it2.pos_second);

  // Particle one moves along the normal, particle two against it.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rv1[i*W +: W] = sat((DW+1)'($signed(vv1[i*W +: W])) + (DW+1)'(dd2[0][i]));
      rv2[i*W +: W] = sat((DW+1)'($signed(vv2[i*W +: W])) - (DW+1)'(dd2[1][i]));
      rp1[i*W +: W] = sat((DW+1)'($signed(pp1[i*W +: W])) + (DW+1)'(dd2[2][i]));
      rp2[i*W +: W] = sat((DW+1)'($signed(pp2[i*W +: W])) - (DW+1)'(dd2[3][i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_item[0]  <= item;
      sd_apply[0] <= apply;
      sd_pos[0]   <= pos;
      for (int k = 1; k < LD; k++) begin
        sd_item[k]  <= sd_item[k-1];
        sd_apply[k] <= sd_apply[k-1];
        sd_pos[k]   <= sd_pos[k-1];
      end

      // A clamped amount still drives every non-zero normal component into saturation.
      it1 <= sd_item[LD-1];
      ap1 <= sd_apply[LD-1];
      for (int j = 0; j < 4; j++) begin
        if (psh[j] > MW'(PC_MAX)) begin
          pc1[j] <= PC_MAX;
        end else begin
          pc1[j] <= psh[j][PCW-1:0];
        end
      end

      it2 <= it1;
      ap2 <= ap1;
      for (int j = 0; j < 4; j++) begin
        for (int i = 0; i < 3; i++) begin
          dd2[j][i] <= dprod[j][i][PCW+W:F];
        end
      end

      res3.new_vel_first   <= VEC_W'(rv1);
      res3.new_vel_second  <= VEC_W'(rv2);
      res3.new_pos_first   <= VEC_W'(rp1);
      res3.new_pos_second  <= VEC_W'(rp2);
      res3.impulse_applied <= ap2;
    end
  end

  assign out_valid = vp3 && !out_full;
  assign result    = res3;

endmodule

/* hdl/particle_contact_resolve_top.sv */
// Accepted contacts pass the front part, mid queue, back part and output queue in order.
// Throughput: one contact per cycle while full is low; the back part's bit-per-stage dividers
// set the depth, and a full output queue holds the back part while the front keeps going.
// Reset (rst, synchronous) empties all queues and pipelines and sets time_step to 1092.
// Top level of the particle contact resolver; uses prc_pkg, prc_front, prc_queue, prc_back.
module particle_contact_resolve_top import prc_pkg::*; #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRACTION_BITS   = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  contact_t          contact,
  output logic              empty,
  input  logic              pop,
  output result_t           result,
  input  logic              time_step_we,
  input  logic [STEP_W-1:0] time_step_wdata
);

  localparam int W         = COMPONENT_WIDTH;
  localparam int A         = 2 * W + 5;
  localparam int MID_DEPTH = 8;
  localparam int OUT_DEPTH = 2;
  localparam int MID_W     = $bits(contact_t) + 2 * A + W + 3;

  logic [STEP_W-1:0] time_step;

  logic         f_valid, f_apply, f_pos;
  contact_t     f_item;
  logic [A-1:0] f_num, f_pnum;
  logic [W:0]   f_total;

  logic             mid_pop, mid_empty, mid_full;
  logic [MID_W-1:0] mid_in, mid_out;

  contact_t     b_item;
  logic [A-1:0] b_num, b_pnum;
  logic [W:0]   b_total;
  logic         b_apply, b_pos;

  logic    out_push, out_full;
  result_t b_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= STEP_RESET;
    end else if (time_step_we) begin
      time_step <= time_step_wdata;
    end
  end

  prc_front #(.W(W), .F(FRACTION_BITS), .DEPTH(MID_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .contact   (contact),
    .time_step (time_step),
    .mid_pop   (mid_pop),
    .out_valid (f_valid),
    .out_item  (f_item),
    .out_num   (f_num),
    .out_pnum  (f_pnum),
    .out_total (f_total),
    .out_apply (f_apply),
    .out_pos   (f_pos)
  );

  assign mid_in = {f_item, f_num, f_pnum, f_total, f_apply, f_pos};

  prc_queue #(.WIDTH(MID_W), .DEPTH(MID_DEPTH)) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_valid),
    .pop   (mid_pop),
    .din   (mid_in),
    .dout  (mid_out),
    .empty (mid_empty),
    .full  (mid_full)
  );

  assign {b_item, b_num, b_pnum, b_total, b_apply, b_pos} = mid_out;

  prc_back #(.W(W), .F(FRACTION_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty || (mid_full && 1'b0)),
    .mid_pop   (mid_pop),
    .item      (b_item),
    .num       (b_num),
    .pnum      (b_pnum),
    .total     (b_total),
    .apply     (b_apply),
    .pos       (b_pos),
    .out_full  (out_full),
    .out_valid (out_push),
    .result    (b_result)
  );

  prc_queue #(.WIDTH($bits(result_t)), .DEPTH(OUT_DEPTH)) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .pop   (pop && !empty),
    .din   (b_result),
    .dout  (result),
    .empty (empty),
    .full  (out_full)
  );

endmodule
